// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked concurrent assertions that are disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold in the same cycle as the trigger.
`define ASSERT_SAME(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error(msg);

// The condition must hold in the cycle after the trigger.
`define ASSERT_NEXT(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error(msg);

`endif

// File: rtl/core/trt_pkg.sv
// ----------------------------------------------------------------------------
// Transaction reference table package
// Sizes, operation codes and status codes used by the table's top level and testbench.
// ----------------------------------------------------------------------------
package trt_pkg;

  localparam int CAPACITY = 64;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int KEY_W    = 64;
  localparam int REF_W    = 64;
  localparam int ENTRY_W  = 2 * KEY_W + REF_W;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_POP    = 2'd1,
    OP_PEEK   = 2'd2,
    OP_UPDATE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_DUP  = 2'd2,
    ST_FULL = 2'd3
  } status_t;

endpackage

// File: rtl/core/trt_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module trt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/core/transaction_ref_table_top.sv
// ----------------------------------------------------------------------------
// Transaction reference table
// Takes one transaction at a time: s_tready is high only in IDLE. The key is
// searched by scanning the single RAM read port one entry per cycle, which
// stops early when the key is found. Reset clears the valid bits; there is no
// clearing pass, so a transaction may be accepted straight after reset.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module transaction_ref_table_top (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [191:0] s_tdata,   // lease_id, rpc_id, new_ref
  input  logic [1:0]   s_tuser,   // operation
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [63:0]  m_tdata,   // ref_out
  output logic [1:0]   m_tuser    // status
);

  typedef enum logic [1:0] {
    IDLE,
    SCAN,
    EXEC
  } state_t;

  state_t                      state;
  trt_pkg::op_t                op;
  logic [trt_pkg::KEY_W-1:0]   lease;
  logic [trt_pkg::KEY_W-1:0]   rpc;
  logic [trt_pkg::REF_W-1:0]   nref;
  logic [trt_pkg::ADDR_W:0]    scan_cnt;
  logic                        chk_vld;
  logic [trt_pkg::ADDR_W-1:0]  chk_idx;
  logic                        hit;
  logic [trt_pkg::ADDR_W-1:0]  hit_idx;
  logic [trt_pkg::REF_W-1:0]   hit_ref;
  logic                        free_found;
  logic [trt_pkg::ADDR_W-1:0]  free_idx;
  logic [trt_pkg::CAPACITY-1:0] valid;

  logic                        ram_we;
  logic [trt_pkg::ADDR_W-1:0]  ram_waddr;
  logic [trt_pkg::ENTRY_W-1:0] ram_wdata;
  logic                        ram_re;
  logic [trt_pkg::ADDR_W-1:0]  ram_raddr;
  logic [trt_pkg::ENTRY_W-1:0] ram_rdata;

  logic                        hit_now;
  logic                        last_chk;
  logic                        out_free;
  logic                        exec_go;
  trt_pkg::status_t            res_status;
  logic [trt_pkg::REF_W-1:0]   res_ref;

  assign s_tready  = (state == IDLE);
  assign ram_re    = (state == SCAN) && !scan_cnt[trt_pkg::ADDR_W];
  assign ram_raddr = scan_cnt[trt_pkg::ADDR_W-1:0];

  assign hit_now  = chk_vld && valid[chk_idx]
                    && (ram_rdata[trt_pkg::KEY_W-1:0] == lease)
                    && (ram_rdata[2*trt_pkg::KEY_W-1:trt_pkg::KEY_W] == rpc);
  assign last_chk = chk_vld && (chk_idx == trt_pkg::ADDR_W'(trt_pkg::CAPACITY - 1));
  assign out_free = !m_tvalid || m_tready;
  assign exec_go  = (state == EXEC) && out_free;

  always_comb begin
    res_status = trt_pkg::ST_OK;
    res_ref    = '0;
    unique case (op)
      trt_pkg::OP_INSERT: begin
        if (hit) begin
          res_status = trt_pkg::ST_DUP;
        end else if (!free_found) begin
          res_status = trt_pkg::ST_FULL;
        end
      end
      trt_pkg::OP_POP, trt_pkg::OP_PEEK: begin
        if (hit) begin
          res_ref = hit_ref;
        end else begin
          res_status = trt_pkg::ST_MISS;
        end
      end
      trt_pkg::OP_UPDATE: begin
        if (!hit) begin
          res_status = trt_pkg::ST_MISS;
        end
      end
      default: begin
        res_status = trt_pkg::ST_OK;
      end
    endcase
  end

  assign ram_we    = exec_go && (((op == trt_pkg::OP_INSERT) && !hit && free_found)
                                 || ((op == trt_pkg::OP_UPDATE) && hit));
  assign ram_waddr = (op == trt_pkg::OP_INSERT) ? free_idx : hit_idx;
  assign ram_wdata = {nref, rpc, lease};

  trt_ram #(
    .WIDTH (trt_pkg::ENTRY_W),
    .DEPTH (trt_pkg::CAPACITY)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IDLE;
      valid      <= '0;
      m_tvalid   <= 1'b0;
      chk_vld    <= 1'b0;
      hit        <= 1'b0;
      free_found <= 1'b0;
      scan_cnt   <= '0;
    end else begin
      if (m_tready && !exec_go) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (s_tvalid) begin
            op         <= trt_pkg::op_t'(s_tuser);
            lease      <= s_tdata[63:0];
            rpc        <= s_tdata[127:64];
            nref       <= s_tdata[191:128];
            scan_cnt   <= '0;
            chk_vld    <= 1'b0;
            hit        <= 1'b0;
            free_found <= 1'b0;
            state      <= SCAN;
          end
        end
        SCAN: begin
          chk_vld <= ram_re;
          if (ram_re) begin
            scan_cnt <= scan_cnt + 1'b1;
            chk_idx  <= ram_raddr;
            if (!free_found && !valid[ram_raddr]) begin
              free_found <= 1'b1;
              free_idx   <= ram_raddr;
            end
          end
          if (hit_now) begin
            hit     <= 1'b1;
            hit_idx <= chk_idx;
            hit_ref <= ram_rdata[trt_pkg::ENTRY_W-1:2*trt_pkg::KEY_W];
            state   <= EXEC;
          end else if (last_chk) begin
            state <= EXEC;
          end
        end
        EXEC: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= res_ref;
            m_tuser  <= res_status;
            if ((op == trt_pkg::OP_INSERT) && !hit && free_found) begin
              valid[free_idx] <= 1'b1;
            end
            if ((op == trt_pkg::OP_POP) && hit) begin
              valid[hit_idx] <= 1'b0;
            end
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  `ASSERT_SAME(a_err_ref_zero, m_tvalid && (m_tuser != trt_pkg::ST_OK), m_tdata == '0,
    "Reference is non-zero on a failed transaction")
  `ASSERT_NEXT(a_pop_clears, exec_go && (op == trt_pkg::OP_POP) && hit,
    !valid[$past(hit_idx)], "Popped entry is still valid")
  `ASSERT_NEXT(a_insert_sets, exec_go && (op == trt_pkg::OP_INSERT) && !hit && free_found,
    valid[$past(free_idx)], "Inserted entry is not valid")
  `ASSERT_SAME(a_write_in_exec, ram_we, exec_go && !ram_re,
    "Entry RAM written outside the result cycle")

endmodule

// File: test/transaction_ref_table_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Transaction reference table testbench
// Sends insert, pop, peek and update requests over the slave stream and checks
// every result on the master stream against a mirror of the table that is
// kept inside the bench. A directed opening covers the key and reference
// extremes, duplicates, misses and zero references. The random part then
// alternates between filling, draining and mixed phases over a small pool of
// keys, so that the table often runs full. Both streams idle at random.
// ----------------------------------------------------------------------------
import trt_pkg::*;

typedef struct {
  logic [63:0] ref_out;
  status_t     status;
} answer_t;

class ref_table_mirror;
  bit          held       [CAPACITY];
  logic [63:0] held_lease [CAPACITY];
  logic [63:0] held_rpc   [CAPACITY];
  logic [63:0] held_ref   [CAPACITY];
  answer_t     answers_due[$];
  int          mismatches;

  function int find_key(logic [63:0] lease, logic [63:0] rpc);
    for (int i = 0; i < CAPACITY; i++)
      if (held[i] && held_lease[i] == lease && held_rpc[i] == rpc) return i;
    return -1;
  endfunction

  function int pending();
    return answers_due.size();
  endfunction

  function void apply_request(op_t op, logic [63:0] lease, logic [63:0] rpc,
                              logic [63:0] new_ref);
    int      hit;
    int      slot;
    answer_t a;
    hit       = find_key(lease, rpc);
    slot      = -1;
    a.ref_out = '0;
    a.status  = ST_OK;
    case (op)
      OP_INSERT: begin
        if (hit >= 0) begin
          a.status = ST_DUP;
        end else begin
          for (int i = CAPACITY - 1; i >= 0; i--)
            if (!held[i]) slot = i;
          if (slot < 0) begin
            a.status = ST_FULL;
          end else begin
            held[slot]       = 1'b1;
            held_lease[slot] = lease;
            held_rpc[slot]   = rpc;
            held_ref[slot]   = new_ref;
          end
        end
      end
      OP_POP, OP_PEEK: begin
        if (hit < 0) begin
          a.status = ST_MISS;
        end else begin
          a.ref_out = held_ref[hit];
          if (op == OP_POP) held[hit] = 1'b0;
        end
      end
      default: begin
        if (hit < 0) a.status = ST_MISS;
        else held_ref[hit] = new_ref;
      end
    endcase
    answers_due.push_back(a);
  endfunction

  task flag_mismatch(string msg);
    $display("mismatch at %0t ns: %s", $time, msg);
    mismatches++;
  endtask

  task check_answer(logic [63:0] ref_out, logic [1:0] status);
    answer_t a;
    if (answers_due.size() == 0) begin
      flag_mismatch($sformatf("unexpected transaction, ref_out %h status %0d",
                              ref_out, status));
      return;
    end
    a = answers_due.pop_front();
    if (ref_out !== a.ref_out)
      flag_mismatch($sformatf("ref_out %h, expected %h", ref_out, a.ref_out));
    if (status !== a.status)
      flag_mismatch($sformatf("status %0d, expected %0d", status, a.status));
  endtask
endclass

module transaction_ref_table_top_tb;

  localparam int POOL_SIZE  = 72;
  localparam int RANDOM_LEN = 1930;
  localparam logic [63:0] ALL_ONES = {64{1'b1}};

  typedef enum {PH_FILL, PH_DRAIN, PH_MIX} phase_t;

  logic         clk      = 1'b0;
  logic         rst      = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [191:0] s_tdata  = '0;
  logic [1:0]   s_tuser  = OP_INSERT;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [63:0]  m_tdata;
  logic [1:0]   m_tuser;

  logic [63:0]  pool_lease [POOL_SIZE];
  logic [63:0]  pool_rpc   [POOL_SIZE];
  bit           steady     = 1'b0;

  ref_table_mirror mirror = new();

  transaction_ref_table_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] pick_ref();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return ALL_ONES;
    return rand64();
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic op_t pick_op(phase_t ph);
    int r;
    r = $urandom_range(0, 99);
    case (ph)
      PH_FILL: begin
        if (r < 70) return OP_INSERT;
        if (r < 80) return OP_PEEK;
        if (r < 90) return OP_UPDATE;
        return OP_POP;
      end
      PH_DRAIN: begin
        if (r < 15) return OP_INSERT;
        if (r < 65) return OP_POP;
        if (r < 85) return OP_PEEK;
        return OP_UPDATE;
      end
      default: return op_t'(r % 4);
    endcase
  endfunction

  // One key in ten comes from outside the pool and will nearly always miss.
  function automatic void pick_key(output logic [63:0] lease, output logic [63:0] rpc);
    int idx;
    if ($urandom_range(0, 9) == 0) begin
      lease = rand64();
      rpc   = rand64();
    end else begin
      idx   = $urandom_range(0, POOL_SIZE - 1);
      lease = pool_lease[idx];
      rpc   = pool_rpc[idx];
    end
  endfunction

  task automatic offer_request(op_t op, logic [63:0] lease, logic [63:0] rpc,
                               logic [63:0] new_ref);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {new_ref, rpc, lease};
    do @(posedge clk); while (!s_tready);
    mirror.apply_request(op, lease, rpc, new_ref);
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) mirror.check_answer(m_tdata, m_tuser);
  end

  initial begin
    int stall;
    while (rst) @(posedge clk);
    forever begin
      stall = pick_gap();
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      repeat (($urandom_range(0, 9) == 0) ? $urandom_range(50, 150)
                                          : $urandom_range(1, 6)) @(posedge clk);
    end
  end

  initial begin
    phase_t      ph;
    int          left;
    op_t         op;
    logic [63:0] lease;
    logic [63:0] rpc;
    logic [63:0] odd_lease;
    logic [63:0] odd_rpc;

    // Some pool keys share one half with their neighbour, so that a match on
    // only one half of the key is exercised.
    pool_lease[0] = '0;
    pool_rpc[0]   = '0;
    pool_lease[1] = ALL_ONES;
    pool_rpc[1]   = ALL_ONES;
    for (int i = 2; i < POOL_SIZE; i++) begin
      pool_lease[i] = ($urandom_range(0, 4) == 0) ? pool_lease[i-1] : rand64();
      pool_rpc[i]   = ($urandom_range(0, 4) == 0) ? pool_rpc[i-1]   : rand64();
    end
    odd_lease = rand64();
    odd_rpc   = rand64();

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    offer_request(OP_PEEK,   '0,        '0,        '0);
    offer_request(OP_INSERT, '0,        '0,        ALL_ONES);
    offer_request(OP_INSERT, ALL_ONES,  ALL_ONES,  '0);
    offer_request(OP_INSERT, '0,        '0,        64'd5);
    offer_request(OP_PEEK,   '0,        '0,        ALL_ONES);
    offer_request(OP_PEEK,   ALL_ONES,  ALL_ONES,  ALL_ONES);
    offer_request(OP_PEEK,   ALL_ONES,  '0,        '0);
    offer_request(OP_INSERT, ALL_ONES,  '0,        64'h0123_4567_89ab_cdef);
    offer_request(OP_INSERT, '0,        ALL_ONES,  64'hfedc_ba98_7654_3210);
    offer_request(OP_UPDATE, ALL_ONES,  ALL_ONES,  64'ha5a5_5a5a_a5a5_5a5a);
    offer_request(OP_PEEK,   ALL_ONES,  ALL_ONES,  '0);
    offer_request(OP_UPDATE, odd_lease, odd_rpc,   ALL_ONES);
    offer_request(OP_PEEK,   odd_lease, odd_rpc,   '0);
    offer_request(OP_POP,    '0,        '0,        '0);
    offer_request(OP_POP,    '0,        '0,        ALL_ONES);
    offer_request(OP_PEEK,   ALL_ONES,  '0,        '0);
    offer_request(OP_INSERT, '0,        '0,        '0);
    offer_request(OP_POP,    '0,        ALL_ONES,  '0);
    offer_request(OP_POP,    ALL_ONES,  ALL_ONES,  '0);
    offer_request(OP_POP,    ALL_ONES,  '0,        '0);
    offer_request(OP_POP,    '0,        '0,        '0);
    offer_request(OP_UPDATE, '0,        '0,        64'h5a5a_a5a5_5a5a_a5a5);

    ph   = PH_FILL;
    left = 200;
    for (int n = 0; n < RANDOM_LEN; n++) begin
      if (left == 0) begin
        ph     = phase_t'($urandom_range(0, 2));
        left   = $urandom_range(60, 200);
        steady = ($urandom_range(0, 4) == 0);
      end
      op = pick_op(ph);
      pick_key(lease, rpc);
      offer_request(op, lease, rpc, pick_ref());
      left--;
    end
    s_tvalid <= 1'b0;

    while (mirror.pending() != 0) @(posedge clk);
    repeat (CAPACITY + 8) @(posedge clk);
    if (mirror.mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
